/* rtl/i2cm_pkg.sv */
// Package for the I2C master byte engine: command codes, result record and
// stream packing constants. No dependencies.
package i2cm_pkg;

    // Bus command codes, as carried in the operation field
    typedef enum logic [2:0] {
        CMD_IDLE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ_ACK  = 3'd3,
        CMD_READ_NACK = 3'd4,
        CMD_STOP      = 3'd5
    } cmd_t;

    // One result item, the state after a tick
    typedef struct packed {
        logic       command_rejected;
        logic [7:0] read_data;
        logic       start_failed;
        logic       ack_received;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_t;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1000;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam int          IN_TDATA_W        = 16;
    localparam int          OUT_TDATA_W       = 16;
    localparam int          RES_W             = $bits(res_t);

endpackage

/* rtl/i2c_master_byte_engine_top.sv */
// I2C master byte engine: one input transaction per bus tick, carrying a
// command and the sampled SDA level; one result transaction per tick giving
// the SCL/SDA drive levels and status. One input transaction is taken every
// cycle as long as results are drained; each result passes through the input
// register, then the sequencer update into the result register. Each bus
// half-phase lasts phase_ticks ticks (reset 1000, zero acts as one), written
// over the cfg port; the user must write it only while no command is running,
// which the block itself does not enforce. Depends on i2cm_pkg and i2cm_seq.
module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tdata: operation[2:0], write_data[10:3], sda_in[11], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tdata: scl_out, sda_out, busy_res, done_res, ack_received,
    // start_failed, read_data[13:6], command_rejected[14], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // phase_ticks register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);

    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;
    logic [15:0]           phase_ticks_reg;
    logic                  adv;
    res_t                  res;

    // Pipeline control
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= PHASE_TICKS_RESET;
        else if (cfg_valid)
            phase_ticks_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
    end

    // Sequencer
    i2cm_seq #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .operation   (in_data_reg[2:0]),
        .write_data  (in_data_reg[10:3]),
        .sda_in      (in_data_reg[11]),
        .phase_ticks (phase_ticks_reg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_reg};

endmodule

/* rtl/i2cm_seq.sv */
// Line sequencer of the I2C master byte engine: holds the bus state and
// advances it by one tick per step. Depends on i2cm_pkg.
module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [2:0]  operation,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    input  logic [15:0] phase_ticks,
    output res_t        res
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int LW = (TW > 16) ? TW : 16;

    // Bus state
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    cmd_t          cmd_reg, cmd_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic          ack_reg, ack_next;
    logic          fail_reg, fail_next;
    logic [7:0]    last_reg, last_next;
    logic          done_c, rej_c;

    logic [LW-1:0] pt_ext, mask_ext, lim;

    // Line action on entering a phase; lines = {scl, sda}
    function automatic logic [1:0] enter_phase(cmd_t c, logic [2:0] p, logic msb,
                                               logic [1:0] lines);
        logic s_scl;
        logic s_sda;
        s_scl = lines[1];
        s_sda = lines[0];
        case (c)
            CMD_START:
            begin
                if (p == 3'd0)
                begin
                    s_scl = 1'b1;
                    s_sda = 1'b1;
                end
                else
                    s_sda = 1'b0;
            end
            CMD_WRITE:
            begin
                if (p == 3'd0 || p == 3'd3 || p == 3'd6)
                    s_scl = 1'b0;
                else if (p == 3'd1)
                    s_sda = msb;
                else if (p == 3'd2 || p == 3'd5)
                    s_scl = 1'b1;
                else if (p == 3'd4)
                    s_sda = 1'b1;
            end
            CMD_READ_ACK, CMD_READ_NACK:
            begin
                if (p == 3'd0 || p == 3'd2 || p == 3'd5)
                    s_scl = 1'b0;
                else if (p == 3'd1 || p == 3'd4)
                    s_scl = 1'b1;
                else if (p == 3'd3)
                    s_sda = (c == CMD_READ_ACK) ? 1'b0 : 1'b1;
            end
            CMD_STOP:
            begin
                if (p == 3'd0)
                    s_scl = 1'b0;
                else if (p == 3'd1)
                    s_sda = 1'b0;
                else if (p == 3'd2)
                    s_scl = 1'b1;
                else
                    s_sda = 1'b1;
            end
            default:
            begin
            end
        endcase
        return {s_scl, s_sda};
    endfunction

    // Phase length: zero acts as one, clipped to the counter range
    always_comb
    begin
        pt_ext   = (phase_ticks == 16'd0) ? LW'(1) : LW'(phase_ticks);
        mask_ext = LW'({TW{1'b1}});
        lim      = (pt_ext > mask_ext) ? mask_ext : pt_ext;
    end

    // One tick of the sequencer
    always_comb
    begin
        logic          is_cmd;
        logic          fin;
        logic [2:0]    nxt;
        logic [TW-1:0] cnt_inc;
        logic [1:0]    lines;

        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        fail_next  = fail_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        rej_c      = 1'b0;
        done_c     = 1'b0;
        fin        = 1'b0;
        nxt        = 3'd0;
        cnt_inc    = '0;
        lines      = 2'b11;

        is_cmd = (operation >= CMD_START) && (operation <= CMD_STOP);

        // Command acceptance
        if (cmd_reg == CMD_IDLE)
        begin
            if (is_cmd)
            begin
                cmd_next   = cmd_t'(operation);
                phase_next = 3'd0;
                bit_next   = 4'd0;
                cnt_next   = '0;
                if (cmd_next == CMD_START)
                    fail_next = 1'b0;
                if (cmd_next == CMD_WRITE)
                begin
                    ack_next   = 1'b0;
                    shift_next = write_data;
                end
                if (cmd_next == CMD_READ_ACK || cmd_next == CMD_READ_NACK)
                begin
                    shift_next = 8'd0;
                    sda_next   = 1'b1;
                end
                lines    = enter_phase(cmd_next, 3'd0, shift_next[7], {scl_next, sda_next});
                scl_next = lines[1];
                sda_next = lines[0];
            end
        end
        else if (is_cmd)
            rej_c = 1'b1;

        // Phase timing and phase end
        if (cmd_next != CMD_IDLE)
        begin
            cnt_inc = cnt_next + TW'(1);
            if (LW'(cnt_inc) >= lim)
            begin
                cnt_next = '0;
                nxt      = phase_next + 3'd1;
                case (cmd_next)
                    CMD_START:
                    begin
                        if (phase_next == 3'd0 && !sda_in)
                        begin
                            fail_next = 1'b1;
                            fin       = 1'b1;
                        end
                        else if (phase_next == 3'd1 && sda_in)
                        begin
                            fail_next = 1'b1;
                            fin       = 1'b1;
                        end
                        else if (phase_next >= 3'd2)
                            fin = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        if (phase_next == 3'd2)
                        begin
                            shift_next = {shift_next[6:0], 1'b0};
                            bit_next   = bit_next + 4'd1;
                            nxt        = (bit_next < BITS_PER_BYTE) ? 3'd0 : 3'd3;
                        end
                        else if (phase_next == 3'd5)
                            ack_next = !sda_in;
                        else if (phase_next >= 3'd6)
                            fin = 1'b1;
                    end
                    CMD_READ_ACK, CMD_READ_NACK:
                    begin
                        if (phase_next == 3'd1)
                        begin
                            shift_next = {shift_next[6:0], sda_in};
                            bit_next   = bit_next + 4'd1;
                            if (bit_next < BITS_PER_BYTE)
                                nxt = 3'd0;
                            else
                            begin
                                last_next = shift_next;
                                nxt       = 3'd2;
                            end
                        end
                        else if (phase_next >= 3'd5)
                            fin = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        if (phase_next >= 3'd3)
                            fin = 1'b1;
                    end
                    default:
                        fin = 1'b1;
                endcase

                if (fin)
                begin
                    cmd_next   = CMD_IDLE;
                    phase_next = 3'd0;
                    bit_next   = 4'd0;
                    done_c     = 1'b1;
                end
                else
                begin
                    phase_next = nxt;
                    lines      = enter_phase(cmd_next, phase_next, shift_next[7],
                                             {scl_next, sda_next});
                    scl_next   = lines[1];
                    sda_next   = lines[0];
                end
            end
            else
                cnt_next = cnt_inc;
        end
    end

    // Result of this tick
    always_comb
    begin
        res.scl_out          = scl_next;
        res.sda_out          = sda_next;
        res.busy_res         = (cmd_next != CMD_IDLE);
        res.done_res         = done_c;
        res.ack_received     = ack_next;
        res.start_failed     = fail_next;
        res.read_data        = last_next;
        res.command_rejected = rej_c;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 3'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            cmd_reg   <= CMD_IDLE;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            last_reg  <= 8'd0;
        end
        else if (step)
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            cmd_reg   <= cmd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            fail_reg  <= fail_next;
            last_reg  <= last_next;
        end
    end

endmodule

/* rtl/i2cm_checker.sv */
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends on i2cm_pkg and i2c_master_byte_engine_top.
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A completing tick never reports the engine as still busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done and busy in one result");

    // With the result side empty, the input side is never held off
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // An offered input is held off only behind a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the result side moves");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
